// ----- hw/rtl/tile_row_fetch_decoder_core_macros.svh -----
// Assertion helpers for the tile row decoder back end.
`ifndef TILE_ROW_FETCH_DECODER_CORE_MACROS_SVH
`define TILE_ROW_FETCH_DECODER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TRFD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tile row decoder check failed");

// The consequent must hold in the cycle after the antecedent.
`define TRFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tile row decoder check failed");

`endif

// ----- hw/rtl/trfd_pkg.sv -----
package trfd_pkg;

   localparam int MemAddrBits  = 16;
   localparam int TileBits     = 9;
   localparam int LaneCount    = 4;
   localparam int LaneSelBits  = 2;
   localparam int LaneAddrBits = MemAddrBits - LaneSelBits;
   localparam int LaneDepth    = 1 << LaneAddrBits;
   localparam int QueueDepth   = 4;

   localparam logic [MemAddrBits-1:0] Base2bppLow  = 16'h2000;
   localparam logic [MemAddrBits-1:0] Base2bppHigh = 16'h4000;
   localparam logic [MemAddrBits-1:0] Base4bppLow  = 16'h4000;
   localparam logic [MemAddrBits-1:0] Base4bppHigh = 16'h8000;

   localparam logic [2:0] ModePlanar4 = 3'd6;
   localparam logic [2:0] ModePacked4 = 3'd7;

   localparam logic CsrVideoMode  = 1'b0;
   localparam logic CsrBankEnable = 1'b1;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_FETCH = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      FMT_2BPP,
      FMT_PLANAR4,
      FMT_PACKED4
   } format_type;

   typedef struct packed {
      logic                   opcode;
      logic [MemAddrBits-1:0] write_address;
      logic [7:0]             write_data;
      logic [TileBits-1:0]    tile_number;
      logic [2:0]             row;
      logic                   flip_vertical;
      logic                   flip_horizontal;
      logic                   bank_select;
   } req_payload_type;

   typedef struct packed {
      logic [3:0] pixel_0;
      logic [3:0] pixel_1;
      logic [3:0] pixel_2;
      logic [3:0] pixel_3;
      logic [3:0] pixel_4;
      logic [3:0] pixel_5;
      logic [3:0] pixel_6;
      logic [3:0] pixel_7;
   } rsp_payload_type;

   // One classified transaction as it waits between the front and the back.
   typedef struct packed {
      opcode_type              op;
      logic [LaneAddrBits-1:0] word_addr;
      logic [LaneSelBits-1:0]  lane;
      logic [7:0]              data;
      format_type              fmt;
      logic                    hflip;
   } queue_entry_type;

endpackage

// ----- hw/rtl/trfd_ram.sv -----
module trfd_ram
   #(parameter int WIDTH = 8,
     parameter int DEPTH = 16384)
   (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
   );

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/trfd_fifo.sv -----
module trfd_fifo
   import trfd_pkg::*;
   #(parameter int DEPTH = QueueDepth)
   (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  queue_entry_type push_entry,
   output logic            full,
   input  logic            pop,
   output logic            not_empty,
   output queue_entry_type head_entry
   );

   localparam int PtrBits   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CountBits = $clog2(DEPTH + 1);
   localparam logic [PtrBits-1:0]   LastPtr   = PtrBits'(DEPTH - 1);
   localparam logic [CountBits-1:0] FullCount = CountBits'(DEPTH);

   queue_entry_type       store_ff [DEPTH];
   logic [PtrBits-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CountBits-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign full       = (count_ff == FullCount);
   assign not_empty  = (count_ff != '0);
   assign head_entry = store_ff[rd_ptr_ff];

endmodule

// ----- hw/rtl/trfd_front.sv -----
module trfd_front
   import trfd_pkg::*;
   (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_write_enable,
   input  logic            csr_index,
   input  logic [2:0]      csr_write_data,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   input  logic            queue_full,
   output logic            push,
   output queue_entry_type push_entry
   );

   logic [2:0]             video_mode_ff, video_mode_in;
   logic                   bank_enable_ff, bank_enable_in;
   logic                   high_bank;
   logic [2:0]             row_eff;
   logic [MemAddrBits-1:0] row_base;
   format_type             fmt;

   always_comb begin
      video_mode_in  = video_mode_ff;
      bank_enable_in = bank_enable_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CsrVideoMode:  video_mode_in  = csr_write_data;
            CsrBankEnable: bank_enable_in = csr_write_data[0];
            default:       video_mode_in  = video_mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         video_mode_ff  <= '0;
         bank_enable_ff <= 1'b0;
      end else begin
         video_mode_ff  <= video_mode_in;
         bank_enable_ff <= bank_enable_in;
      end
   end

   assign high_bank = req_payload.bank_select && bank_enable_ff;
   assign row_eff   = req_payload.flip_vertical ? (3'd7 - req_payload.row) : req_payload.row;

   always_comb begin
      case (video_mode_ff)
         ModePacked4: fmt = FMT_PACKED4;
         ModePlanar4: fmt = FMT_PLANAR4;
         default:     fmt = FMT_2BPP;
      endcase
   end

   // 4bpp rows are four bytes and 2bpp rows two bytes, both aligned, so one
   // read of the four byte lanes covers the whole row.
   always_comb begin
      if (fmt == FMT_2BPP) begin
         row_base = (high_bank ? Base2bppHigh : Base2bppLow)
                  + {3'b000, req_payload.tile_number, 4'b0000}
                  + {12'b0, row_eff, 1'b0};
      end else begin
         row_base = (high_bank ? Base4bppHigh : Base4bppLow)
                  + {2'b00, req_payload.tile_number, 5'b00000}
                  + {11'b0, row_eff, 2'b00};
      end
   end

   always_comb begin
      push_entry.op    = opcode_type'(req_payload.opcode);
      push_entry.data  = req_payload.write_data;
      push_entry.fmt   = fmt;
      push_entry.hflip = req_payload.flip_horizontal;
      if (req_payload.opcode == OP_WRITE) begin
         push_entry.word_addr = req_payload.write_address[MemAddrBits-1:LaneSelBits];
         push_entry.lane      = req_payload.write_address[LaneSelBits-1:0];
      end else begin
         push_entry.word_addr = row_base[MemAddrBits-1:LaneSelBits];
         push_entry.lane      = row_base[LaneSelBits-1:0];
      end
   end

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

endmodule

// ----- hw/rtl/trfd_back.sv -----
module trfd_back
   import trfd_pkg::*;
   (
   input  logic            clock,
   input  logic            reset,
   input  logic            queue_not_empty,
   input  queue_entry_type head_entry,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
   );

   `include "tile_row_fetch_decoder_core_macros.svh"

   logic [LaneCount-1:0] ram_we;
   logic                 ram_re;
   logic [7:0]           lane_data [LaneCount];

   logic                 head_is_fetch;
   logic                 out_ready;
   logic                 s1_advance;

   logic                 s1_valid_ff, s1_valid_in;
   format_type           s1_fmt_ff;
   logic                 s1_upper_ff;
   logic                 s1_hflip_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_payload_ff;

   logic [7:0]           b0, b1, b2, b3;
   logic [3:0]           px [8];
   logic [3:0]           ordered [8];

   for (genvar l = 0; l < LaneCount; l++) begin : g_lane
      trfd_ram #(
         .WIDTH (8),
         .DEPTH (LaneDepth)
      ) u_ram (
         .clock   (clock),
         .wr_en   (ram_we[l]),
         .wr_addr (head_entry.word_addr),
         .wr_data (head_entry.data),
         .rd_en   (ram_re),
         .rd_addr (head_entry.word_addr),
         .rd_data (lane_data[l])
      );
      assign ram_we[l] = pop && (head_entry.op == OP_WRITE)
                       && (head_entry.lane == LaneSelBits'(l));
   end

   assign head_is_fetch = (head_entry.op == OP_FETCH);
   assign out_ready     = !rsp_valid_ff || !rsp_stall;
   assign s1_advance    = s1_valid_ff && out_ready;
   // Writes never wait; a fetch needs the read stage to be free or draining.
   assign pop    = queue_not_empty && (!head_is_fetch || !s1_valid_ff || s1_advance);
   assign ram_re = pop && head_is_fetch;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (ram_re) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_re) begin
         s1_fmt_ff   <= head_entry.fmt;
         s1_upper_ff <= head_entry.lane[1];
         s1_hflip_ff <= head_entry.hflip;
      end
      if (s1_advance) begin
         rsp_payload_ff <= '{pixel_0: ordered[0], pixel_1: ordered[1],
                             pixel_2: ordered[2], pixel_3: ordered[3],
                             pixel_4: ordered[4], pixel_5: ordered[5],
                             pixel_6: ordered[6], pixel_7: ordered[7]};
      end
   end

   // A 2bpp row sits in the lower or the upper lane pair of the word.
   always_comb begin
      b0 = lane_data[0];
      b1 = lane_data[1];
      b2 = lane_data[2];
      b3 = lane_data[3];
      if (s1_fmt_ff == FMT_2BPP) begin
         b0 = s1_upper_ff ? lane_data[2] : lane_data[0];
         b1 = s1_upper_ff ? lane_data[3] : lane_data[1];
         b2 = '0;
         b3 = '0;
      end
   end

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         px[i] = {b3[7-i], b2[7-i], b1[7-i], b0[7-i]};
      end
      case (s1_fmt_ff)
         FMT_PACKED4: begin
            px[0] = b0[7:4];
            px[1] = b0[3:0];
            px[2] = b1[7:4];
            px[3] = b1[3:0];
            px[4] = b2[7:4];
            px[5] = b2[3:0];
            px[6] = b3[7:4];
            px[7] = b3[3:0];
         end
         FMT_PLANAR4, FMT_2BPP: begin
            px[0] = {b3[7], b2[7], b1[7], b0[7]};
         end
         default: begin
            px[0] = {b3[7], b2[7], b1[7], b0[7]};
         end
      endcase
      for (int i = 0; i < 8; i++) begin
         ordered[i] = s1_hflip_ff ? px[7-i] : px[i];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `TRFD_ASSERT_SAME(a_no_write_during_read, clock, reset, ram_re, ram_we == '0)
   `TRFD_ASSERT_NEXT(a_fetch_reaches_stage, clock, reset, ram_re, s1_valid_ff)
   `TRFD_ASSERT_NEXT(a_stage_reaches_output, clock, reset, s1_advance, rsp_valid_ff)
   `TRFD_ASSERT_NEXT(a_blocked_fetch_kept, clock, reset, s1_valid_ff && !s1_advance, s1_valid_ff)

endmodule

// ----- hw/rtl/tile_row_fetch_decoder_core.sv -----
// A fetch transaction's row goes through the queue, the memory read and the decode into the
// output register before it is valid at the output. Throughput: one transaction per cycle
// while nothing stalls; every row is a single read of four byte-lane RAMs.
// Writes give no result and retire in the cycle they leave the queue.
// Reset clears the queue, the pipeline valids and both configuration registers;
// video memory is not cleared and reads back undefined until written.
module tile_row_fetch_decoder_core
   import trfd_pkg::*;
   #(parameter int QUEUE_DEPTH = QueueDepth)
   (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_write_enable,
   input  logic            csr_index,
   input  logic [2:0]      csr_write_data,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
   );

   logic            queue_full;
   logic            queue_not_empty;
   logic            push;
   logic            pop;
   queue_entry_type push_entry;
   queue_entry_type head_entry;

   trfd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .queue_full       (queue_full),
      .push             (push),
      .push_entry       (push_entry)
   );

   trfd_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .not_empty  (queue_not_empty),
      .head_entry (head_entry)
   );

   trfd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_not_empty (queue_not_empty),
      .head_entry      (head_entry),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_payload     (rsp_payload)
   );

endmodule
